// ===== hw/rtl/tsn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_pkg
// Types, character codes and the per-byte rewrite rules of the text spacing
// normalizer. The look-back window keeps its newest byte at index 0.
// ----------------------------------------------------------------------------
package tsn_pkg;

  localparam int unsigned WIN_DEPTH = 5;  // bytes of output history
  localparam int unsigned MAX_EMIT  = 5;  // words one item can produce
  localparam int unsigned Q_DEPTH   = 8;  // output queue entries

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] NBSP_LEAD = 8'd194;
  localparam logic [7:0] NBSP_TAIL = 8'd160;
  localparam logic [7:0] GUIL_OPEN = 8'd171;
  localparam logic [7:0] GUIL_CLS  = 8'd187;
  localparam logic [7:0] UTF_E2    = 8'd226;
  localparam logic [7:0] UTF_80    = 8'd128;
  localparam logic [7:0] QUOTE_OPN = 8'd156;
  localparam logic [7:0] QUOTE_CLS = 8'd157;
  localparam logic [7:0] ELLIPSIS  = 8'd166;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_empty;
  } out_item_t;

  // words produced by one item, oldest in items[0]
  typedef struct packed {
    logic [2:0]                   count;
    out_item_t [MAX_EMIT-1:0]     items;
  } emit_t;

  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] win;     // [0] is the newest byte
    logic [2:0]                known;   // valid bytes in win
    logic [2:0]                hold;    // newest bytes not yet sent
    logic [2:0]                ecount;  // cleaned length, saturates at 7
  } win_state_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL);
  endfunction

  function automatic logic is_closer(logic [7:0] c);
    return c inside {8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h21, 8'h3F, 8'h29, 8'h5D, 8'h7D};
  endfunction

  function automatic logic is_opener(logic [7:0] c);
    return c inside {8'h28, 8'h5B, 8'h7B};
  endfunction

  // i-th newest byte, 0 when outside the known history
  function automatic logic [7:0] back_byte(win_state_t s, logic [2:0] i);
    logic [7:0] b;
    b = CH_NUL;
    if (i != 3'd0 && i <= s.known && i <= 3'(WIN_DEPTH)) begin
      b = s.win[i - 3'd1];
    end
    return b;
  endfunction

  function automatic win_state_t put_byte(win_state_t s, logic [7:0] b);
    win_state_t r;
    r = s;
    r.win = {s.win[WIN_DEPTH-2:0], b};
    if (s.known < 3'(WIN_DEPTH)) r.known = s.known + 3'd1;
    if (s.hold < 3'(WIN_DEPTH)) r.hold = s.hold + 3'd1;
    if (s.ecount != 3'd7) r.ecount = s.ecount + 3'd1;
    return r;
  endfunction

  function automatic win_state_t drop_byte(win_state_t s);
    win_state_t r;
    r = s;
    r.win = {CH_NUL, s.win[WIN_DEPTH-1:1]};
    if (s.known != 3'd0) r.known = s.known - 3'd1;
    if (s.hold != 3'd0) r.hold = s.hold - 3'd1;
    if (s.ecount != 3'd0) r.ecount = s.ecount - 3'd1;
    return r;
  endfunction

  // one pass of the rules for a mapped character
  function automatic win_state_t rule_pass(win_state_t s, logic [7:0] ch);
    win_state_t r;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       done;
    r    = s;
    done = 1'b0;
    b1   = back_byte(s, 3'd1);
    b2   = back_byte(s, 3'd2);
    b3   = back_byte(s, 3'd3);
    if (is_blank(ch)) begin
      if (s.ecount == 3'd0) begin
        done = 1'b1;                      // leading blank
      end else if (b1 == CH_SPACE) begin
        r.win[0] = ch;                    // newline beats space
        done = 1'b1;
      end else if (b1 == CH_NL) begin
        done = 1'b1;
      end
    end
    if (!done && s.ecount != 3'd0) begin
      if (is_closer(ch)) begin
        if (b1 == CH_SPACE) begin
          r    = drop_byte(s);            // caller runs a second pass
          done = 1'b1;
        end
      end else if (ch == GUIL_CLS) begin
        if (b1 == NBSP_LEAD && s.ecount >= 3'd2 && b2 == CH_SPACE) begin
          r.win[1] = NBSP_LEAD;
          r.win[0] = GUIL_CLS;
          done     = 1'b1;
        end
      end else if (ch == QUOTE_CLS) begin
        if (b1 == UTF_80 && s.ecount >= 3'd3 && b2 == UTF_E2 && b3 == CH_SPACE) begin
          r.win[2] = UTF_E2;
          r.win[1] = UTF_80;
          r.win[0] = QUOTE_CLS;
          done     = 1'b1;
        end
      end else if (ch == CH_SPACE) begin
        if (is_opener(b1)) begin
          done = 1'b1;
        end else if (b1 == GUIL_OPEN && s.ecount >= 3'd2 && b2 == NBSP_LEAD) begin
          done = 1'b1;
        end else if (b1 == QUOTE_OPN && s.ecount >= 3'd3 && b2 == UTF_80 &&
                     b3 == UTF_E2) begin
          done = 1'b1;
        end
      end
      if (!done && ch == CH_DOT) begin
        if (b1 == CH_DOT) begin
          if (s.ecount >= 3'd2 && b2 == CH_DOT) begin
            r.win[1] = UTF_E2;
            r.win[0] = UTF_80;
            r        = put_byte(r, ELLIPSIS);
            done     = 1'b1;
          end
        end else if (b1 == ELLIPSIS && s.ecount >= 3'd3 && b2 == UTF_80 &&
                     b3 == UTF_E2) begin
          done = 1'b1;                    // dots after an ellipsis
        end
      end
    end
    if (!done) r = put_byte(s, ch);
    return r;
  endfunction

  // full handling of one raw byte (tab/CR mapping, closer re-check)
  function automatic win_state_t process_char(win_state_t s, logic [7:0] x);
    win_state_t r;
    logic [7:0] ch;
    logic       again;
    ch = x;
    if (x == CH_TAB) ch = CH_SPACE;
    else if (x == CH_CR) ch = CH_NL;
    // space before a closer: drop it, then evaluate the closer again
    again = is_closer(ch) && s.ecount != 3'd0 && back_byte(s, 3'd1) == CH_SPACE;
    r = rule_pass(s, ch);
    if (again) r = rule_pass(r, ch);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tsn_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_core
// Window state and rewrite logic: applies one registered item per cycle
// while go is high and hands out the words that leave the hold window.
// ----------------------------------------------------------------------------
module tsn_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire tsn_pkg::in_item_t word,
  output tsn_pkg::emit_t        emit
);
  import tsn_pkg::*;

  win_state_t st;
  win_state_t st_next;
  logic       pend;
  logic       pend_next;

  always_comb begin
    win_state_t s;
    logic       p;
    logic [2:0] limit;
    logic [2:0] idx;
    s         = st;
    p         = pend;
    limit     = 3'd3;
    idx       = 3'd0;
    emit      = '0;
    st_next   = st;
    pend_next = pend;
    if (go) begin
      if (word.text_byte != CH_NUL) begin
        if (p && word.text_byte == NBSP_TAIL) begin
          p = 1'b0;
          s = drop_byte(s);
          s = process_char(s, CH_SPACE);
        end else begin
          s = process_char(s, word.text_byte);
          p = (word.text_byte == NBSP_LEAD);
        end
      end
      if (word.is_last) begin
        if (s.ecount != 3'd0 && is_blank(back_byte(s, 3'd1))) s = drop_byte(s);
        if (s.hold == 3'd0) begin
          emit.count              = 3'd1;
          emit.items[0].out_byte  = CH_NUL;
          emit.items[0].out_last  = 1'b1;
          emit.items[0].out_empty = 1'b1;
        end else begin
          emit.count = s.hold;
          for (int j = 0; j < MAX_EMIT; j++) begin
            idx = s.hold - 3'd1 - 3'(j);
            if (3'(j) < s.hold && idx < 3'(WIN_DEPTH)) begin
              emit.items[j].out_byte = s.win[idx];
              emit.items[j].out_last = (idx == 3'd0);
            end
          end
        end
        // text done: back to the reset state
        s.known  = 3'd0;
        s.hold   = 3'd0;
        s.ecount = 3'd0;
        p        = 1'b0;
      end else begin
        limit = p ? 3'd4 : 3'd3;
        if (s.hold > limit) begin
          emit.count = s.hold - limit;
          for (int j = 0; j < MAX_EMIT; j++) begin
            idx = s.hold - 3'd1 - 3'(j);
            if (3'(j) < emit.count && idx < 3'(WIN_DEPTH)) begin
              emit.items[j].out_byte = s.win[idx];
            end
          end
          s.hold = limit;
        end
      end
      st_next   = s;
      pend_next = p;
    end
  end

  always_ff @(posedge clk) begin
    st.win <= st_next.win;
    if (rst) begin
      st.known  <= 3'd0;
      st.hold   <= 3'd0;
      st.ecount <= 3'd0;
      pend      <= 1'b0;
    end else begin
      st.known  <= st_next.known;
      st.hold   <= st_next.hold;
      st.ecount <= st_next.ecount;
      pend      <= pend_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tsn_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsn_outq
// Output queue: takes up to five words per cycle, sends one per cycle from
// the head entry while the receiver does not stall.
// ----------------------------------------------------------------------------
module tsn_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tsn_pkg::emit_t     emit,
  output logic                    room,
  output logic                    valid,
  input  wire logic               stall,
  output tsn_pkg::out_item_t      word
);
  import tsn_pkg::*;

  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  out_item_t [Q_DEPTH-1:0] q;
  out_item_t [Q_DEPTH-1:0] q_next;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_next;

  assign valid = (cnt != '0);
  assign word  = q[0];
  // an item may add MAX_EMIT words
  assign room  = (cnt <= CW'(Q_DEPTH - MAX_EMIT));

  always_comb begin
    logic [CW-1:0] base;
    logic [CW-1:0] off;
    q_next = q;
    base   = cnt;
    if (valid && !stall) begin
      for (int k = 0; k < Q_DEPTH - 1; k++) q_next[k] = q[k + 1];
      base = cnt - CW'(1);
    end
    for (int k = 0; k < Q_DEPTH; k++) begin
      off = CW'(k) - base;
      if (CW'(k) >= base && off < CW'(emit.count) && off < CW'(MAX_EMIT)) begin
        q_next[k] = emit.items[off[2:0]];
      end
    end
    cnt_next = base + CW'(emit.count);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/text_spacing_normalizer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_spacing_normalizer_core
// Cleans the spacing of a UTF-8 byte stream: blank mapping and collapsing,
// space removal around punctuation and quotes, three dots to an ellipsis.
// ----------------------------------------------------------------------------
// Usage:
//   text channel  : one input word per accepted cycle (text_byte, is_last).
//                   text_byte 0 carries no byte; is_last ends the text and
//                   flushes the held bytes.
//   clean channel : cleaned bytes, oldest first; out_last marks the final
//                   word of a text, out_empty a text that came out empty
//                   (one word, byte 0).
//   Throughput: one word per cycle in each direction while no side stalls.
//   A word is registered, applied to the window once the queue has room
//   and then written into the output queue. Up to four bytes stay held for
//   later rewrites, so a byte usually leaves only after later bytes arrive
//   or at is_last. The output queue holds 8 words; the registered word is
//   applied while it holds at most 3, since a flush can add 5 words at once.
//   A stalled receiver fills the queue past 3 words, then text_stall rises.
//   Reset (rst, synchronous) empties the queue and the window; after each
//   is_last the window returns to its reset state on its own.
// ----------------------------------------------------------------------------
module text_spacing_normalizer_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                text_valid,
  output logic                     text_stall,
  input  wire tsn_pkg::in_item_t   text_word,
  output logic                     clean_valid,
  input  wire logic                clean_stall,
  output tsn_pkg::out_item_t       clean_word
);
  import tsn_pkg::*;

  in_item_t ireg;       // input register
  logic     ireg_v;
  logic     room;       // queue can take a worst-case item
  logic     go;         // registered word is applied this cycle
  emit_t    emit;

  assign go         = ireg_v && room;
  assign text_stall = ireg_v && !room;

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) ireg <= text_word;
    if (rst) begin
      ireg_v <= 1'b0;
    end else if (text_valid && !text_stall) begin
      ireg_v <= 1'b1;
    end else if (go) begin
      ireg_v <= 1'b0;
    end
  end

  // window state and rewrite rules
  tsn_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .word (ireg),
    .emit (emit)
  );

  // result queue toward the clean side
  tsn_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .emit  (emit),
    .room  (room),
    .valid (clean_valid),
    .stall (clean_stall),
    .word  (clean_word)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: text spacing normalizer testbench
// Drives texts into text_spacing_normalizer_core one word at a time and
// checks every cleaned word against a byte-level model of the spacing rules
// kept in this file. Directed texts cover the blank, dot, guillemet and quote
// rules; random texts follow, mostly well-formed UTF-8 tokens with some noise.
// The sender runs in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsn_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000; // slowest legal run is far below
  localparam int unsigned HOLD_OFF_CYCLES = 120;    // long receiver hold-off
  localparam int unsigned END_SETTLE      = 20;     // quiet cycles after the last word

  // printable bytes used as plain text or as rule triggers
  localparam logic [7:0] CH_LETTER_A = 8'h61;
  localparam logic [7:0] CH_LETTER_X = 8'h78;
  localparam logic [7:0] CH_LETTER_Y = 8'h79;
  localparam logic [7:0] CH_LETTER_Z = 8'h7A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_EXCL     = 8'h21;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_RBRACK   = 8'h5D;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;

  logic      clk;
  logic      rst;
  logic      text_valid;
  logic      text_stall;
  in_item_t  text_word;
  logic      clean_valid;
  logic      clean_stall = 1'b0;
  out_item_t clean_word;

  text_spacing_normalizer_core dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_word  (text_word),
    .clean_valid(clean_valid),
    .clean_stall(clean_stall),
    .clean_word (clean_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Spacing model. The window holds the newest output bytes, newest at [0].
  // win_known counts the valid ones, held counts the newest bytes not yet
  // sent, clean_len is the cleaned length so far (saturates at 7).
  // --------------------------------------------------------------------------
  logic [7:0]  win [WIN_DEPTH];
  int unsigned win_known;
  int unsigned held;
  int unsigned clean_len;
  bit          lead_pend;    // newest byte is a 194 that may start a no-break space

  out_item_t   clean_q[$];   // cleaned words still to come, oldest first
  int unsigned errors;
  int unsigned words_offered; // words that carry a byte or end a text
  int unsigned cycles;

  // sender pacing
  int unsigned burst_left;
  bit          no_gaps;

  // receiver pacing
  bit          rx_free;
  bit          hold_off_req;
  bit          hold_off_ack;
  int unsigned hold_off_left;
  int unsigned rx_tick;
  int unsigned rx_mode;

  function automatic void clear_text_state();
    foreach (win[i]) win[i] = CH_NUL;
    win_known = 0;
    held      = 0;
    clean_len = 0;
    lead_pend = 1'b0;
  endfunction

  // i-th newest byte; 0 when it is outside the known history
  function automatic logic [7:0] look_back(int unsigned i);
    if (i == 0 || i > win_known) return CH_NUL;
    return win[i-1];
  endfunction

  function automatic void poke_back(int unsigned i, logic [7:0] v);
    if (i != 0 && i <= win_known) win[i-1] = v;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (win_known < WIN_DEPTH) win_known++;
    if (held < WIN_DEPTH) held++;
    if (clean_len < 7) clean_len++;
  endfunction

  function automatic void pop_newest();
    for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i+1];
    win[WIN_DEPTH-1] = CH_NUL;
    if (win_known != 0) win_known--;
    if (held != 0) held--;
    if (clean_len != 0) clean_len--;
  endfunction

  function automatic bit ends_clause(logic [7:0] c);
    case (c)
      CH_DOT, CH_COMMA, CH_SEMI, CH_COLON, CH_EXCL, CH_QUEST,
      CH_RPAREN, CH_RBRACK, CH_RBRACE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // one mapped character against the look-back rules
  function automatic void apply_char(logic [7:0] c);
    logic [7:0] ch;
    logic [7:0] b1;
    ch = c;
    if (c == CH_TAB) ch = CH_SPACE;
    else if (c == CH_CR) ch = CH_NL;
    while (1) begin
      if (ch == CH_SPACE || ch == CH_NL) begin
        if (clean_len == 0) return;                 // leading blank
        if (look_back(1) == CH_SPACE) begin
          poke_back(1, ch);                         // newline wins over space
          return;
        end
        if (look_back(1) == CH_NL) return;
      end
      if (clean_len != 0) begin
        b1 = look_back(1);
        if (ends_clause(ch)) begin
          if (b1 == CH_SPACE) begin
            pop_newest();                           // then look at the closer again
            continue;
          end
        end else if (ch == GUIL_CLS) begin
          if (b1 == NBSP_LEAD && clean_len >= 2 && look_back(2) == CH_SPACE) begin
            poke_back(2, NBSP_LEAD);
            poke_back(1, GUIL_CLS);
            return;
          end
        end else if (ch == QUOTE_CLS) begin
          if (b1 == UTF_80 && clean_len >= 3 && look_back(2) == UTF_E2 &&
              look_back(3) == CH_SPACE) begin
            poke_back(3, UTF_E2);
            poke_back(2, UTF_80);
            poke_back(1, QUOTE_CLS);
            return;
          end
        end else if (ch == CH_SPACE) begin
          if (b1 == CH_LPAREN || b1 == CH_LBRACK || b1 == CH_LBRACE) return;
          if (b1 == GUIL_OPEN && clean_len >= 2 && look_back(2) == NBSP_LEAD) return;
          if (b1 == QUOTE_OPN && clean_len >= 3 && look_back(2) == UTF_80 &&
              look_back(3) == UTF_E2) return;
        end
        if (ch == CH_DOT) begin
          if (b1 == CH_DOT) begin
            if (clean_len >= 2 && look_back(2) == CH_DOT) begin
              poke_back(2, UTF_E2);                 // three dots to an ellipsis
              poke_back(1, UTF_80);
              push_byte(ELLIPSIS);
              return;
            end
          end else if (b1 == ELLIPSIS && clean_len >= 3 && look_back(2) == UTF_80 &&
                       look_back(3) == UTF_E2) begin
            return;                                 // dots after an ellipsis
          end
        end
      end
      push_byte(ch);
      return;
    end
  endfunction

  // expected cleaned words for one accepted text word
  function automatic void predict_clean(logic [7:0] x, logic last);
    out_item_t   w;
    int unsigned cap;
    if (x != CH_NUL) begin
      if (lead_pend && x == NBSP_TAIL) begin
        lead_pend = 1'b0;
        pop_newest();
        apply_char(CH_SPACE);
      end else begin
        lead_pend = 1'b0;
        apply_char(x);
        if (x == NBSP_LEAD) lead_pend = 1'b1;
      end
    end
    if (last) begin
      if (clean_len != 0 && (look_back(1) == CH_SPACE || look_back(1) == CH_NL))
        pop_newest();                               // one trailing blank goes
      if (held == 0) begin
        w.out_byte  = CH_NUL;
        w.out_last  = 1'b1;
        w.out_empty = 1'b1;
        clean_q.push_back(w);
      end else begin
        while (held > 0 && held <= win_known) begin
          w.out_byte  = win[held-1];
          w.out_last  = (held == 1);
          w.out_empty = 1'b0;
          clean_q.push_back(w);
          held--;
        end
      end
      clear_text_state();
    end else begin
      cap = lead_pend ? 4 : 3;
      while (held > cap && held <= win_known) begin
        w.out_byte  = win[held-1];
        w.out_last  = 1'b0;
        w.out_empty = 1'b0;
        clean_q.push_back(w);
        held--;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one text word per call, bursts of random length with random gaps.
  // Inputs change at the falling edge; acceptance is seen at the rising edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        @(negedge clk);
        text_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    text_valid          <= 1'b1;
    text_word.text_byte <= b;
    text_word.is_last   <= last;
    do @(posedge clk); while (text_stall);
    if (b != CH_NUL || last) words_offered++;
    predict_clean(b, last);
  endtask

  // a text either ends on its final byte or with a separate flush word
  task automatic send_text(input logic [7:0] txt[$], input bit flush);
    for (int i = 0; i < txt.size(); i++)
      send_word(txt[i], !flush && i == txt.size() - 1);
    if (flush || txt.size() == 0) send_word(CH_NUL, 1'b1);
  endtask

  // sender stops and waits until every expected word has come back
  task automatic wait_drained();
    @(negedge clk);
    text_valid <= 1'b0;
    while (clean_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one random token: plain letters, blanks, punctuation, UTF-8 sequences
  function automatic void add_token(ref logic [7:0] txt[$]);
    logic [7:0] closers [9];
    closers = '{CH_DOT, CH_COMMA, CH_SEMI, CH_COLON, CH_EXCL, CH_QUEST,
                CH_RPAREN, CH_RBRACK, CH_RBRACE};
    case ($urandom_range(0, 17))
      0, 1, 2: txt.push_back(8'($urandom_range(CH_LETTER_A, CH_LETTER_Z)));
      3, 4:    txt.push_back(CH_SPACE);
      5:       txt.push_back(CH_TAB);
      6:       txt.push_back($urandom_range(0, 1) ? CH_CR : CH_NL);
      7, 8:    txt.push_back(CH_DOT);
      9:       txt.push_back(closers[$urandom_range(0, 8)]);
      10: begin
        case ($urandom_range(0, 2))
          0:       txt.push_back(CH_LPAREN);
          1:       txt.push_back(CH_LBRACK);
          default: txt.push_back(CH_LBRACE);
        endcase
      end
      11: begin                                   // no-break space
        txt.push_back(NBSP_LEAD);
        txt.push_back(NBSP_TAIL);
      end
      12: begin                                   // guillemet
        txt.push_back(NBSP_LEAD);
        txt.push_back($urandom_range(0, 1) ? GUIL_OPEN : GUIL_CLS);
      end
      13: begin                                   // curly quote
        txt.push_back(UTF_E2);
        txt.push_back(UTF_80);
        txt.push_back($urandom_range(0, 1) ? QUOTE_OPN : QUOTE_CLS);
      end
      14: begin                                   // ready-made ellipsis
        txt.push_back(UTF_E2);
        txt.push_back(UTF_80);
        txt.push_back(ELLIPSIS);
      end
      15: txt.push_back(NBSP_LEAD);               // lone lead byte
      16: txt.push_back(CH_NUL);                  // no byte in mid text
      default: txt.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_text();
    send_word(CH_NUL, 1'b0);                      // no byte: ignored
    send_word(CH_NUL, 1'b1);                      // flush only, empty text
    send_text('{CH_TAB}, 1'b0);                   // a leading blank alone
  endtask

  task automatic test_blanks_and_dots();
    // leading blank, tab before a dot, ellipsis, extra dot, newline beats
    // space, blank after a newline, trailing newline, flush word
    send_text('{CH_SPACE, CH_LETTER_A, CH_TAB, CH_DOT, CH_DOT, CH_DOT, CH_DOT,
                CH_SPACE, CH_CR, CH_TAB}, 1'b1);
  endtask

  task automatic test_guillemets();
    // no-break space after an opening guillemet, space before a closing one,
    // 194 ending the text
    send_text('{NBSP_LEAD, GUIL_OPEN, NBSP_LEAD, NBSP_TAIL, CH_LETTER_X, CH_SPACE,
                NBSP_LEAD, GUIL_CLS, NBSP_LEAD}, 1'b0);
  endtask

  task automatic test_curly_quotes();
    send_text('{UTF_E2, UTF_80, QUOTE_OPN, CH_TAB, CH_LETTER_Y, CH_SPACE,
                UTF_E2, UTF_80, QUOTE_CLS}, 1'b0);
  endtask

  task automatic test_random_texts(input int unsigned n_words);
    logic [7:0]  txt[$];
    int unsigned target;
    int unsigned n_tok;
    bit          noise;
    target = words_offered + n_words;
    while (words_offered < target) begin
      txt.delete();
      noise = ($urandom_range(0, 14) == 0);
      case ($urandom_range(0, 9))
        0:       n_tok = 0;
        1:       n_tok = $urandom_range(20, 40);
        default: n_tok = $urandom_range(1, 12);
      endcase
      for (int i = 0; i < n_tok; i++) begin
        if (noise) txt.push_back(8'($urandom_range(0, 255)));
        else add_token(txt);
      end
      send_text(txt, $urandom_range(0, 2) == 0);
    end
  endtask

  // back-to-back words with a receiver that never stalls
  task automatic test_full_rate();
    no_gaps = 1'b1;
    rx_free = 1'b1;
    test_random_texts(40);
    wait_drained();
    no_gaps = 1'b0;
    rx_free = 1'b0;
  endtask

  // receiver holds off while the sender keeps going: queue fills, input stalls
  task automatic test_backpressure();
    logic [7:0] txt[$];
    for (int i = 0; i < 30; i++) add_token(txt);
    no_gaps      = 1'b1;
    hold_off_req = ~hold_off_req;
    send_text(txt, 1'b0);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst                 = 1'b1;
    text_valid          = 1'b0;
    text_word.text_byte = CH_NUL;
    text_word.is_last   = 1'b0;
    errors              = 0;
    words_offered       = 0;
    burst_left          = 0;
    no_gaps             = 1'b0;
    rx_free             = 1'b0;
    hold_off_req        = 1'b0;
    clear_text_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_text();
    test_blanks_and_dots();
    test_guillemets();
    test_curly_quotes();
    wait_drained();
    test_full_rate();
    test_backpressure();
    test_random_texts(140);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern (free, light, heavy, alternating) picked at random;
  // a requested hold-off overrides it for a long stretch.
  // --------------------------------------------------------------------------
  initial begin
    hold_off_ack  = 1'b0;
    hold_off_left = 0;
    rx_tick       = 0;
    rx_mode       = 0;
  end

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_off_req != hold_off_ack) begin
      hold_off_ack  <= hold_off_req;
      hold_off_left <= HOLD_OFF_CYCLES;
      clean_stall   <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      clean_stall   <= 1'b1;
    end else if (rx_free || rst) begin
      clean_stall <= 1'b0;
    end else begin
      case (rx_mode)
        0:       clean_stall <= 1'b0;
        1:       clean_stall <= ($urandom_range(0, 3) == 0);
        2:       clean_stall <= ($urandom_range(0, 3) != 0);
        default: clean_stall <= rx_tick[1];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each accepted cleaned word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_clean
    out_item_t want;
    if (!rst && clean_valid && !clean_stall) begin
      if (clean_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got byte %0d last %0b empty %0b",
                 $time, clean_word.out_byte, clean_word.out_last, clean_word.out_empty);
      end else begin
        want = clean_q.pop_front();
        if (clean_word.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %0d, got %0d",
                   $time, want.out_byte, clean_word.out_byte);
        end
        if (clean_word.out_last !== want.out_last) begin
          errors++;
          $display("%0t: out_last expected %0b, got %0b",
                   $time, want.out_last, clean_word.out_last);
        end
        if (clean_word.out_empty !== want.out_empty) begin
          errors++;
          $display("%0t: out_empty expected %0b, got %0b",
                   $time, want.out_empty, clean_word.out_empty);
        end
      end
    end
  end

  // watchdog
  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
